### rtl/tpd_pkg.sv
// Shared types and constants for the three-point derivative unit.
// Used by tpd_ctrl, tpd_dp and three_point_derivative_unit; no dependencies.
`default_nettype none
package tpd_pkg;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_SHORT = 2'd1;
	localparam logic [1:0] ST_EQUAL = 2'd2;
	localparam logic [1:0] ST_SAT   = 2'd3;

	// multiply phases of one derivative
	localparam logic [2:0] PH_P1A = 3'd0;  // first product, first factor
	localparam logic [2:0] PH_P1B = 3'd1;  // first product, second factor
	localparam logic [2:0] PH_P2A = 3'd2;  // second product, first factor
	localparam logic [2:0] PH_P2B = 3'd3;  // second product, second factor
	localparam logic [2:0] PH_DNA = 3'd4;  // denominator, first factor
	localparam logic [2:0] PH_DNB = 3'd5;  // denominator, second factor

	localparam logic [1:0] AT_FIRST = 2'd0;
	localparam logic [1:0] AT_MID   = 2'd1;
	localparam logic [1:0] AT_LAST  = 2'd2;

	typedef enum logic [1:0] {
		KIND_CALC  = 2'd0,
		KIND_SHORT = 2'd1,
		KIND_EQUAL = 2'd2
	} kind_t;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_START  = 8'b0000_0010,
		S_MSTART = 8'b0000_0100,
		S_MUL    = 8'b0000_1000,
		S_DSTART = 8'b0001_0000,
		S_DIV    = 8'b0010_0000,
		S_ROUND  = 8'b0100_0000,
		S_EMIT   = 8'b1000_0000
	} state_t;

	typedef struct packed {
		logic       win_wr;
		logic       win_shift;
		logic [1:0] win_idx;
		logic       win_clr;
		logic       mul_start;
		logic       mul_step;
		logic [2:0] phase;
		logic [1:0] at;
		logic       div_start;
		logic       div_step;
		logic       round;
		logic       out_load;
		kind_t      kind;
		logic       run_end;
	} tpd_cmd_t;

	typedef struct packed {
		logic hzero;
		logic mul_done;
		logic div_done;
		logic out_free;
	} tpd_sts_t;

endpackage
`default_nettype wire

### rtl/tpd_ctrl.sv
// Controller of the three-point derivative unit: run bookkeeping and the
// multiply/divide sequence. Depends on tpd_pkg.
`default_nettype none
module tpd_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              last_point,
	input  wire tpd_pkg::tpd_sts_t sts,
	output tpd_pkg::tpd_cmd_t      cmd
);

	tpd_pkg::state_t state_q, state_n;
	logic [1:0]      cnt_q, cnt_n;
	logic [1:0]      at_q, at_n;
	logic [1:0]      end_q, end_n;
	logic            last_q, last_n;
	logic [2:0]      ph_q, ph_n;
	tpd_pkg::kind_t  kind_q, kind_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tpd_pkg::S_IDLE;
			cnt_q   <= 2'd0;
			at_q    <= 2'd0;
			end_q   <= 2'd0;
			last_q  <= 1'b0;
			ph_q    <= 3'd0;
			kind_q  <= tpd_pkg::KIND_CALC;
		end else begin
			state_q <= state_n;
			cnt_q   <= cnt_n;
			at_q    <= at_n;
			end_q   <= end_n;
			last_q  <= last_n;
			ph_q    <= ph_n;
			kind_q  <= kind_n;
		end
	end

	assign in_ready = (state_q == tpd_pkg::S_IDLE);

	always_comb begin
		state_n = state_q;
		cnt_n   = cnt_q;
		at_n    = at_q;
		end_n   = end_q;
		last_n  = last_q;
		ph_n    = ph_q;
		kind_n  = kind_q;
		cmd     = '0;
		cmd.phase   = ph_q;
		cmd.at      = at_q;
		cmd.kind    = kind_q;
		cmd.run_end = (kind_q == tpd_pkg::KIND_SHORT) || (last_q && at_q == end_q);
		cmd.win_idx = cnt_q;
		case (state_q)
			tpd_pkg::S_IDLE: begin
				if (in_valid) begin
					last_n = last_point;
					if (cnt_q < 2'd2) begin
						if (last_point) begin
							kind_n  = tpd_pkg::KIND_SHORT;
							state_n = tpd_pkg::S_EMIT;
						end else begin
							cmd.win_wr = 1'b1;
							cnt_n      = cnt_q + 2'd1;
						end
					end else begin
						if (cnt_q == 2'd2) begin
							cmd.win_wr = 1'b1;
							at_n       = tpd_pkg::AT_FIRST;
						end else begin
							cmd.win_shift = 1'b1;
							at_n          = tpd_pkg::AT_MID;
						end
						cnt_n   = 2'd3;
						end_n   = last_point ? tpd_pkg::AT_LAST : tpd_pkg::AT_MID;
						state_n = tpd_pkg::S_START;
					end
				end
			end
			tpd_pkg::S_START: begin
				if (sts.hzero) begin
					kind_n  = tpd_pkg::KIND_EQUAL;
					state_n = tpd_pkg::S_EMIT;
				end else begin
					kind_n  = tpd_pkg::KIND_CALC;
					ph_n    = tpd_pkg::PH_P1A;
					state_n = tpd_pkg::S_MSTART;
				end
			end
			tpd_pkg::S_MSTART: begin
				cmd.mul_start = 1'b1;
				state_n       = tpd_pkg::S_MUL;
			end
			tpd_pkg::S_MUL: begin
				cmd.mul_step = 1'b1;
				if (sts.mul_done) begin
					if (ph_q == tpd_pkg::PH_DNB) begin
						state_n = tpd_pkg::S_DSTART;
					end else begin
						ph_n    = ph_q + 3'd1;
						state_n = tpd_pkg::S_MSTART;
					end
				end
			end
			tpd_pkg::S_DSTART: begin
				cmd.div_start = 1'b1;
				state_n       = tpd_pkg::S_DIV;
			end
			tpd_pkg::S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					state_n = tpd_pkg::S_ROUND;
				end
			end
			tpd_pkg::S_ROUND: begin
				cmd.round = 1'b1;
				state_n   = tpd_pkg::S_EMIT;
			end
			tpd_pkg::S_EMIT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					if (kind_q == tpd_pkg::KIND_SHORT || at_q == end_q) begin
						if (last_q) begin
							cmd.win_clr = 1'b1;
							cnt_n       = 2'd0;
						end
						state_n = tpd_pkg::S_IDLE;
					end else begin
						at_n    = at_q + 2'd1;
						state_n = tpd_pkg::S_START;
					end
				end
			end
			default: begin
				state_n = tpd_pkg::S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

### rtl/tpd_dp.sv
// Datapath of the three-point derivative unit: point window, bit-serial
// multiplier, restoring divider, rounding, saturation, output register.
// Depends on tpd_pkg.
`default_nettype none
module tpd_dp #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [DATA_WIDTH-1:0] x_value,
	input  wire logic [DATA_WIDTH-1:0] y_value,
	input  wire tpd_pkg::tpd_cmd_t     cmd,
	output tpd_pkg::tpd_sts_t          sts,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [DATA_WIDTH-1:0]      derivative,
	output logic [1:0]                 status,
	output logic                       run_end
);

	localparam int W   = DATA_WIDTH;
	localparam int NW  = 3 * W + FRAC_BITS + 4;  // holds every product exactly
	localparam int M   = W + 3;                  // factor width (2*h1 + h2)
	localparam int MCW = $clog2(M);
	localparam int DCW = $clog2(NW);

	logic [W-1:0] x_win_q [3];
	logic [W-1:0] y_win_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				x_win_q[i] <= '0;
				y_win_q[i] <= '0;
			end
		end else if (cmd.win_clr) begin
			for (int i = 0; i < 3; i++) begin
				x_win_q[i] <= '0;
				y_win_q[i] <= '0;
			end
		end else if (cmd.win_shift) begin
			x_win_q[0] <= x_win_q[1];
			y_win_q[0] <= y_win_q[1];
			x_win_q[1] <= x_win_q[2];
			y_win_q[1] <= y_win_q[2];
			x_win_q[2] <= x_value;
			y_win_q[2] <= y_value;
		end else if (cmd.win_wr) begin
			case (cmd.win_idx)
				2'd0: begin
					x_win_q[0] <= x_value;
					y_win_q[0] <= y_value;
				end
				2'd1: begin
					x_win_q[1] <= x_value;
					y_win_q[1] <= y_value;
				end
				2'd2: begin
					x_win_q[2] <= x_value;
					y_win_q[2] <= y_value;
				end
				default: begin
				end
			endcase
		end
	end

	// exact differences, two's complement in W+1 bits
	logic [W:0] h1, h2, hh, da, db;
	assign h1 = {x_win_q[1][W-1], x_win_q[1]} - {x_win_q[0][W-1], x_win_q[0]};
	assign h2 = {x_win_q[2][W-1], x_win_q[2]} - {x_win_q[1][W-1], x_win_q[1]};
	assign hh = {x_win_q[2][W-1], x_win_q[2]} - {x_win_q[0][W-1], x_win_q[0]};
	assign da = {y_win_q[1][W-1], y_win_q[1]} - {y_win_q[0][W-1], y_win_q[0]};
	assign db = {y_win_q[2][W-1], y_win_q[2]} - {y_win_q[1][W-1], y_win_q[1]};

	assign sts.hzero = (h1 == '0) || (h2 == '0) || (hh == '0);

	logic [M-1:0] f_h1, f_h2, f_hh, f_hh_h1, f_hh_h2;
	assign f_h1    = {{2{h1[W]}}, h1};
	assign f_h2    = {{2{h2[W]}}, h2};
	assign f_hh    = {{2{hh[W]}}, hh};
	assign f_hh_h1 = f_hh + f_h1;
	assign f_hh_h2 = f_hh + f_h2;

	logic [NW-1:0] w_h1, w_a, w_b;
	assign w_h1 = {{(NW-W-1){h1[W]}}, h1};
	assign w_a  = {{(NW-W-1){da[W]}}, da};
	assign w_b  = {{(NW-W-1){db[W]}}, db};

	// multiplier
	logic [NW-1:0]  t_q, num_q, den_q, mc_q, acc_q, mc_init, acc_n, addend;
	logic [M-1:0]   mp_q, fac;
	logic [MCW-1:0] mcnt_q;
	logic           m_last;

	always_comb begin
		case (cmd.phase)
			tpd_pkg::PH_P1A: mc_init = (cmd.at == tpd_pkg::AT_LAST) ? w_b : w_a;
			tpd_pkg::PH_P2A: mc_init = (cmd.at == tpd_pkg::AT_LAST) ? w_a : w_b;
			tpd_pkg::PH_DNA: mc_init = w_h1;
			default:         mc_init = t_q;
		endcase
		case (cmd.phase)
			tpd_pkg::PH_P1A: fac = (cmd.at == tpd_pkg::AT_LAST) ? f_h1 : f_h2;
			tpd_pkg::PH_P1B: begin
				case (cmd.at)
					tpd_pkg::AT_FIRST: fac = f_hh_h1;
					tpd_pkg::AT_MID:   fac = f_h2;
					default:           fac = f_hh_h2;
				endcase
			end
			tpd_pkg::PH_P2A,
			tpd_pkg::PH_P2B: fac = (cmd.at == tpd_pkg::AT_LAST) ? f_h2 : f_h1;
			tpd_pkg::PH_DNA: fac = f_h2;
			tpd_pkg::PH_DNB: fac = f_hh;
			default:         fac = f_h1;
		endcase
	end

	assign m_last       = (mcnt_q == MCW'(M - 1));
	// top factor bit carries negative weight
	assign addend       = mp_q[0] ? (m_last ? (~mc_q + NW'(1)) : mc_q) : '0;
	assign acc_n        = acc_q + addend;
	assign sts.mul_done = m_last;

	always_ff @(posedge clk) begin
		if (cmd.mul_start) begin
			mc_q   <= mc_init;
			mp_q   <= fac;
			acc_q  <= '0;
			mcnt_q <= '0;
		end else if (cmd.mul_step) begin
			mc_q   <= {mc_q[NW-2:0], 1'b0};
			mp_q   <= {1'b0, mp_q[M-1:1]};
			acc_q  <= acc_n;
			mcnt_q <= mcnt_q + MCW'(1);
			if (m_last) begin
				t_q <= acc_n;
				case (cmd.phase)
					tpd_pkg::PH_P1B: num_q <= acc_n;
					tpd_pkg::PH_P2B: num_q <= (cmd.at == tpd_pkg::AT_MID) ?
						num_q + acc_n : num_q - acc_n;
					tpd_pkg::PH_DNB: den_q <= acc_n;
					default: begin
					end
				endcase
			end
		end
	end

	// divider: |num| * 2^FRAC_BITS / |den|, one quotient bit per cycle
	logic [NW-1:0]  num_abs, den_abs, dq_q, d_q, rem_q, rem_n;
	logic [NW:0]    rs;
	logic [DCW-1:0] dcnt_q;
	logic           neg_q, q_bit, rnd_up;

	assign num_abs = num_q[NW-1] ? (~num_q + NW'(1)) : num_q;
	assign den_abs = den_q[NW-1] ? (~den_q + NW'(1)) : den_q;
	assign rs      = {rem_q, dq_q[NW-1]};
	assign q_bit   = (rs >= {1'b0, d_q});
	assign rem_n   = q_bit ? NW'(rs - {1'b0, d_q}) : rs[NW-1:0];
	assign sts.div_done = (dcnt_q == DCW'(NW - 1));
	assign rnd_up  = ({rem_q, 1'b0} >= {1'b0, d_q});

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dq_q   <= num_abs << FRAC_BITS;
			d_q    <= den_abs;
			rem_q  <= '0;
			dcnt_q <= '0;
			neg_q  <= num_q[NW-1] ^ den_q[NW-1];
		end else if (cmd.div_step) begin
			dq_q   <= {dq_q[NW-2:0], q_bit};
			rem_q  <= rem_n;
			dcnt_q <= dcnt_q + DCW'(1);
		end else if (cmd.round) begin
			dq_q <= dq_q + NW'(rnd_up);
		end
	end

	// saturation against the signed output range
	logic [NW-1:0] lim, mag_neg;
	logic          sat;
	logic [W-1:0]  calc_val;
	assign lim      = (NW'(1) << (W - 1)) - NW'(!neg_q);
	assign sat      = (dq_q > lim);
	assign mag_neg  = ~dq_q + NW'(1);
	assign calc_val = sat ? (neg_q ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}}) :
		(neg_q ? mag_neg[W-1:0] : dq_q[W-1:0]);

	logic out_valid_q;
	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			run_end <= cmd.run_end;
			case (cmd.kind)
				tpd_pkg::KIND_SHORT: begin
					derivative <= '0;
					status     <= tpd_pkg::ST_SHORT;
				end
				tpd_pkg::KIND_EQUAL: begin
					derivative <= '0;
					status     <= tpd_pkg::ST_EQUAL;
				end
				default: begin
					derivative <= calc_val;
					status     <= sat ? tpd_pkg::ST_SAT : tpd_pkg::ST_OK;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

### rtl/three_point_derivative_unit.sv
// Three-point derivative over a stream of (x, y) points on an uneven grid.
// Top level: joins tpd_ctrl and tpd_dp; depends on tpd_pkg.
//
// Each accepted point updates a three-point window; every derivative is the
// slope of the quadratic through the window, computed exactly and rounded
// half away from zero. Each derivative runs six factor passes through the
// bit-serial multiplier, then the restoring divider and a rounding step;
// a point that releases two or three results runs that sequence once per
// result. Points that only fill the window are written without leaving idle,
// and triples with equal abscissae skip the multiplier and divider. Input is
// taken only between items; a finished result sits in an output register
// while the next one is computed.
`default_nettype none
module three_point_derivative_unit #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [DATA_WIDTH-1:0] x_value,
	input  wire logic [DATA_WIDTH-1:0] y_value,
	input  wire logic                  last_point,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [DATA_WIDTH-1:0]      derivative,
	output logic [1:0]                 status,
	output logic                       run_end
);

	tpd_pkg::tpd_cmd_t cmd;
	tpd_pkg::tpd_sts_t sts;

	tpd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.last_point (last_point),
		.sts        (sts),
		.cmd        (cmd)
	);

	tpd_dp #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.x_value    (x_value),
		.y_value    (y_value),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.derivative (derivative),
		.status     (status),
		.run_end    (run_end)
	);

endmodule
`default_nettype wire

### tb/tb.sv
// Self-checking bench for three_point_derivative_unit: runs of (x, y) points,
// slopes predicted in wide exact arithmetic. Depends on rtl/tpd_pkg.sv and the RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [191:0] wide_t;

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic        last;
	} point_t;

	typedef struct {
		logic [31:0] deriv;
		logic [1:0]  st;
		logic        fin;
	} slope_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] x_value = '0;
	logic [31:0] y_value = '0;
	logic        last_point = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] derivative;
	logic [1:0]  status;
	logic        run_end;

	point_t pending_points[$];
	slope_t expected_slopes[$];

	// predictor window, oldest first
	logic signed [31:0] xw[3];
	logic signed [31:0] yw[3];
	int unsigned        held = 0;

	int unsigned gap_in = 0, stall_out = 0;
	bit          in_taken = 0, out_taken = 0;
	int unsigned mismatches = 0, slopes_checked = 0, points_sent = 0;
	int unsigned n_short = 0, n_equal = 0, n_sat = 0;

	three_point_derivative_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.x_value(x_value), .y_value(y_value), .last_point(last_point),
		.out_valid(out_valid), .out_ready(out_ready),
		.derivative(derivative), .status(status), .run_end(run_end)
	);

	always #1 clk = ~clk;

	function automatic slope_t slope_of(int at, logic fin);
		wide_t  h1, h2, hh, a, b, num, den, nm, dm, q, r, lim;
		logic   neg;
		slope_t s;
		s.fin = fin;
		s.deriv = '0;
		h1 = wide_t'(xw[1]) - wide_t'(xw[0]);
		h2 = wide_t'(xw[2]) - wide_t'(xw[1]);
		hh = wide_t'(xw[2]) - wide_t'(xw[0]);
		a = wide_t'(yw[1]) - wide_t'(yw[0]);
		b = wide_t'(yw[2]) - wide_t'(yw[1]);
		if (h1 == 0 || h2 == 0 || hh == 0) begin
			s.st = tpd_pkg::ST_EQUAL;
			return s;
		end
		if (at == 0)
			num = a * h2 * (hh + h1) - b * h1 * h1;
		else if (at == 1)
			num = a * h2 * h2 + b * h1 * h1;
		else
			num = b * h1 * (hh + h2) - a * h2 * h2;
		num = num <<< 16;
		den = h1 * h2 * hh;
		neg = (num < 0) ^ (den < 0);
		nm = (num < 0) ? -num : num;
		dm = (den < 0) ? -den : den;
		q = nm / dm;
		r = nm % dm;
		if (2 * r >= dm)
			q = q + 1;
		lim = neg ? (wide_t'(1) <<< 31) : ((wide_t'(1) <<< 31) - 1);
		if (q > lim) begin
			s.st = tpd_pkg::ST_SAT;
			s.deriv = neg ? 32'h8000_0000 : 32'h7fff_ffff;
		end else begin
			s.st = tpd_pkg::ST_OK;
			s.deriv = neg ? -q[31:0] : q[31:0];
		end
		return s;
	endfunction

	// update window for one accepted point and queue the slopes it releases
	task automatic take_point(logic [31:0] xv, logic [31:0] yv, logic fin);
		slope_t s;
		if (held < 2) begin
			if (fin) begin
				s.deriv = '0;
				s.st = tpd_pkg::ST_SHORT;
				s.fin = 1'b1;
				expected_slopes.push_back(s);
				held = 0;
			end else begin
				xw[held] = xv;
				yw[held] = yv;
				held++;
			end
			return;
		end
		if (held == 2) begin
			xw[2] = xv;
			yw[2] = yv;
			expected_slopes.push_back(slope_of(0, 1'b0));
		end else begin
			xw[0] = xw[1]; yw[0] = yw[1];
			xw[1] = xw[2]; yw[1] = yw[2];
			xw[2] = xv; yw[2] = yv;
		end
		expected_slopes.push_back(slope_of(1, 1'b0));
		held = 3;
		if (fin) begin
			expected_slopes.push_back(slope_of(2, 1'b1));
			held = 0;
		end
	endtask

	function automatic int unsigned draw_wait();
		if ($urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(0, 11);
	endfunction

	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			take_point(x_value, y_value, last_point);
			points_sent++;
			in_taken = 1;
		end
		if (out_valid && out_ready) begin
			out_taken = 1;
			slopes_checked++;
			if (status == tpd_pkg::ST_SHORT) n_short++;
			if (status == tpd_pkg::ST_EQUAL) n_equal++;
			if (status == tpd_pkg::ST_SAT) n_sat++;
			if (expected_slopes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transaction: deriv=%h status=%0d run_end=%0d",
						derivative, status, run_end);
			end else begin
				slope_t e;
				e = expected_slopes.pop_front();
				if (e.deriv !== derivative || e.st !== status || e.fin !== run_end) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp deriv=%h st=%0d end=%0d, got deriv=%h st=%0d end=%0d",
							e.deriv, e.st, e.fin, derivative, status, run_end);
				end
			end
		end
	end

	// input driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_taken || !in_valid) begin
				if (in_taken) begin
					in_taken = 0;
					gap_in = draw_wait();
				end else if (gap_in > 0) begin
					gap_in--;
				end
				if (gap_in == 0 && pending_points.size() != 0) begin
					point_t p;
					p = pending_points.pop_front();
					x_value <= p.x;
					y_value <= p.y;
					last_point <= p.last;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output stall
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_taken) begin
				out_taken = 0;
				stall_out = draw_wait();
				out_ready <= (stall_out == 0);
			end else if (!out_ready) begin
				if (stall_out > 0)
					stall_out--;
				else
					out_ready <= 1'b1;
			end
		end
	end

	task automatic add_point(logic [31:0] xv, logic [31:0] yv, logic fin);
		point_t p;
		p.x = xv;
		p.y = yv;
		p.last = fin;
		pending_points.push_back(p);
	endtask

	// one random run: mostly a random walk in x, sometimes raw values or repeated x
	task automatic add_run();
		int unsigned n, i, mode;
		logic [31:0] xv, yv;
		mode = $urandom_range(0, 9);
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
		xv = $urandom;
		for (i = 0; i < n; i++) begin
			if (mode == 0) begin
				xv = $urandom;
				yv = $urandom;
			end else begin
				if (mode == 1 && $urandom_range(0, 2) == 0)
					xv = xv;
				else if ($urandom_range(0, 1) == 0)
					xv = xv + $urandom_range(1, 1 << $urandom_range(0, 20));
				else
					xv = xv - $urandom_range(1, 1 << $urandom_range(0, 20));
				yv = $signed($urandom) >>> $urandom_range(0, 31);
			end
			add_point(xv, yv, i == n - 1);
		end
	endtask

	initial begin
		// short runs: one point, then two points
		add_point(32'h0001_0000, 32'h7fff_ffff, 1'b1);
		add_point(32'h0, 32'h0, 1'b0);
		add_point(32'h0002_0000, 32'h8000_0000, 1'b1);
		// repeated abscissae
		add_point(32'h0005_0000, 32'h1, 1'b0);
		add_point(32'h0005_0000, 32'h2, 1'b0);
		add_point(32'h0006_0000, 32'h3, 1'b1);
		// full-range abscissae and ordinates
		add_point(32'h8000_0000, 32'h8000_0000, 1'b0);
		add_point(32'h0, 32'h7fff_ffff, 1'b0);
		add_point(32'h7fff_ffff, 32'h8000_0000, 1'b0);
		add_point(32'hffff_ffff, 32'hffff_ffff, 1'b1);
		// tiny steps, huge swings: saturation both ways
		add_point(32'h0, 32'h8000_0000, 1'b0);
		add_point(32'h1, 32'h7fff_ffff, 1'b0);
		add_point(32'h2, 32'h8000_0000, 1'b0);
		add_point(32'h3, 32'h7fff_ffff, 1'b1);
		// uneven grid on a parabola, x descending
		add_point(32'h0003_0000, 32'h0009_0000, 1'b0);
		add_point(32'h0001_0000, 32'h0001_0000, 1'b0);
		add_point(32'hffff_0000, 32'h0001_0000, 1'b0);
		add_point(32'hfffc_0000, 32'h0010_0000, 1'b0);
		add_point(32'hfffb_8000, 32'h0014_4000, 1'b1);
		while (pending_points.size() < 180)
			add_run();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		while (pending_points.size() != 0 || in_valid || expected_slopes.size() != 0)
			@(posedge clk);
		repeat (1500) @(posedge clk);
		if (expected_slopes.size() != 0) begin
			mismatches += expected_slopes.size();
			$display("%0d expected transactions never arrived", expected_slopes.size());
		end
		$display("Sent %0d points, checked %0d slopes (%0d short-run, %0d equal-x, %0d saturated)",
			points_sent, slopes_checked, n_short, n_equal, n_sat);
		$display("%0d mismatches", mismatches);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#8ms;
		$display("Timeout with %0d points pending, %0d slopes expected",
			pending_points.size(), expected_slopes.size());
		$display("Regression FAIL");
		$finish;
	end
endmodule
